// ===== src/sph_pkg.sv =====
// Shared types, constants and helpers of the spherical coordinate converter.
// No dependencies; used by sph_cordic and spherical_coordinate_convert.
package sph_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int CW           = 24;
	localparam int OW           = 25;
	localparam int VW           = 40;
	localparam int AW           = 34;
	localparam int GUARD        = 8;
	localparam int PW           = 64;
	localparam int RW           = PW - 30;

	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [AW-1:0] ang_t;
	typedef logic signed [RW-1:0] comp_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [OW-1:0] res_t;

	typedef enum logic {
		OP_CART2SPH = 1'b0,
		OP_SPH2CART = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_OFFSET_X = 2'd0,
		REG_OFFSET_Y = 2'd1,
		REG_OFFSET_Z = 2'd2
	} reg_t;

	localparam ang_t HALF_TURN    = ang_t'(64'sh80000000);
	localparam ang_t QUARTER_TURN = ang_t'(64'sh40000000);
	localparam logic signed [31:0] INV_GAIN = 32'sh26DD3B6A;

	localparam ang_t ATAN_TAB [TABLE_LEN] = '{
		ang_t'(32'h20000000), ang_t'(32'h12E4051E), ang_t'(32'h09FB385B),
		ang_t'(32'h051111D4), ang_t'(32'h028B0D43), ang_t'(32'h0145D7E1),
		ang_t'(32'h00A2F61E), ang_t'(32'h00517C55), ang_t'(32'h0028BE53),
		ang_t'(32'h00145F2F), ang_t'(32'h000A2F98), ang_t'(32'h000517CC),
		ang_t'(32'h00028BE6), ang_t'(32'h000145F3), ang_t'(32'h0000A2FA),
		ang_t'(32'h0000517D), ang_t'(32'h000028BE), ang_t'(32'h0000145F),
		ang_t'(32'h00000A30), ang_t'(32'h00000518), ang_t'(32'h0000028C),
		ang_t'(32'h00000146), ang_t'(32'h000000A3), ang_t'(32'h00000051)
	};

	typedef struct packed {
		vec_t x;
		vec_t y;
		ang_t a;
	} cvec_t;

	typedef struct packed {
		op_t    op;
		coord_t c;
		ang_t   phi;
		logic   ab_zero;
		logic   rho_zero;
		ang_t   axy;
		comp_t  zv;
	} side_t;

	// fold the vector into the convergence range of the micro-rotations
	function automatic cvec_t cordic_pre(input op_t op, input cvec_t v);
		cvec_t r;
		r = v;
		if (op == OP_CART2SPH) begin
			if (v.x < 0) begin
				r.a = (v.y >= 0) ? HALF_TURN : -HALF_TURN;
				r.x = -v.x;
				r.y = -v.y;
			end
		end else if (v.a > QUARTER_TURN) begin
			r.a = v.a - HALF_TURN;
			r.x = -v.x;
			r.y = -v.y;
		end else if (v.a < -QUARTER_TURN) begin
			r.a = v.a + HALF_TURN;
			r.x = -v.x;
			r.y = -v.y;
		end
		return r;
	endfunction

	// drop guard bits with rounding, then scale by the inverse gain
	function automatic prod_t gain_mul(input vec_t v);
		vec_t r;
		logic signed [31:0] t;
		r = v + vec_t'(1 << (GUARD - 1));
		t = r[VW-1:GUARD];
		return prod_t'(t) * prod_t'(INV_GAIN);
	endfunction

	function automatic comp_t gain_rnd(input prod_t p);
		prod_t r;
		r = p + (prod_t'(1) <<< 29);
		return r[PW-1:30];
	endfunction

endpackage

// ===== src/spherical_coordinate_convert.sv =====
// Top level of the Cartesian / spherical converter with centre offset.
// Depends on sph_pkg and sph_cordic.

// Takes one point per clock and gives one result per point, in order. It is two
// 16-stage CORDIC pipelines in series, each followed by a two-stage gain multiply,
// plus input and output registers. A stall at the output holds the whole pipeline.
// Offset registers are written through the cfg port, which is always ready; the
// user must write them only while the block is idle; it does not enforce this.
module spherical_coordinate_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // in_a, in_b, in_c
	input  logic        s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // out_a, out_b, out_c, zero pad
	output logic        m_axis_tuser,  // saturated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import sph_pkg::*;

	logic   en;
	coord_t off_x_q, off_y_q, off_z_q;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
		end else if (cfg_valid) begin
			unique case (reg_t'(cfg_index))
				REG_OFFSET_X: off_x_q <= cfg_data;
				REG_OFFSET_Y: off_y_q <= cfg_data;
				REG_OFFSET_Z: off_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	coord_t in_a, in_b, in_c;
	op_t    in_op;
	cvec_t  pre1;
	side_t  side_in;

	assign in_a  = s_axis_tdata[23:0];
	assign in_b  = s_axis_tdata[47:24];
	assign in_c  = s_axis_tdata[71:48];
	assign in_op = op_t'(s_axis_tuser);

	always_comb begin
		cvec_t v;
		v.x = {{(VW-CW-GUARD){in_a[CW-1]}}, in_a, {GUARD{1'b0}}};
		v.y = (in_op == OP_CART2SPH) ? {{(VW-CW-GUARD){in_b[CW-1]}}, in_b, {GUARD{1'b0}}} : '0;
		v.a = (in_op == OP_CART2SPH) ? '0 : {{(AW-32){in_c[15]}}, in_c[15:0], 16'b0};
		pre1             = cordic_pre(in_op, v);
		side_in.op       = in_op;
		side_in.c        = in_c;
		side_in.phi      = {{(AW-32){in_b[15]}}, in_b[15:0], 16'b0};
		side_in.ab_zero  = (in_a == '0) && (in_b == '0);
		side_in.rho_zero = 1'b0;
		side_in.axy      = '0;
		side_in.zv       = '0;
	end

	logic  valid_s1;
	cvec_t vec_s1;
	side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1  <= pre1;
			side_s1 <= side_in;
		end
	end

	// first pass
	logic  c1_valid;
	cvec_t c1_vec;
	side_t c1_side;

	sph_cordic u_pass1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s1),
		.in_vec    (vec_s1),
		.in_side   (side_s1),
		.out_valid (c1_valid),
		.out_vec   (c1_vec),
		.out_side  (c1_side)
	);

	logic  valid_s2, valid_s3;
	prod_t px_s2, py_s2;
	ang_t  ang_s2;
	side_t side_s2, side_s3;
	comp_t rx_s3, ry_s3;
	ang_t  ang_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= c1_valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2   <= gain_mul(c1_vec.x);
			py_s2   <= gain_mul(c1_vec.y);
			ang_s2  <= c1_vec.a;
			side_s2 <= c1_side;
			rx_s3   <= gain_rnd(px_s2);
			ry_s3   <= gain_rnd(py_s2);
			ang_s3  <= ang_s2;
			side_s3 <= side_s2;
		end
	end

	// second pass input
	cvec_t pre2;
	side_t side_mid;

	always_comb begin
		cvec_t v;
		comp_t rho;
		vec_t  rho_v;
		vec_t  c_v;
		rho   = (side_s3.op == OP_CART2SPH) ? rx_s3 : ry_s3;
		rho_v = {rho[VW-GUARD-1:0], {GUARD{1'b0}}};
		c_v   = {{(VW-CW-GUARD){side_s3.c[CW-1]}}, side_s3.c, {GUARD{1'b0}}};
		if (side_s3.op == OP_CART2SPH) begin
			v.x = c_v;
			v.y = rho_v;
			v.a = '0;
		end else begin
			v.x = rho_v;
			v.y = '0;
			v.a = side_s3.phi;
		end
		pre2              = cordic_pre(side_s3.op, v);
		side_mid          = side_s3;
		side_mid.rho_zero = (rho == '0) && (side_s3.c == '0);
		side_mid.axy      = ang_s3;
		side_mid.zv       = rx_s3;
	end

	logic  c2_valid;
	cvec_t c2_vec;
	side_t c2_side;

	sph_cordic u_pass2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_vec    (pre2),
		.in_side   (side_mid),
		.out_valid (c2_valid),
		.out_vec   (c2_vec),
		.out_side  (c2_side)
	);

	logic  valid_s4, valid_s5;
	prod_t px_s4, py_s4;
	ang_t  ang_s4, ang_s5;
	side_t side_s4, side_s5;
	comp_t rx_s5, ry_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= c2_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s4   <= gain_mul(c2_vec.x);
			py_s4   <= gain_mul(c2_vec.y);
			ang_s4  <= c2_vec.a;
			side_s4 <= c2_side;
			rx_s5   <= gain_rnd(px_s4);
			ry_s5   <= gain_rnd(py_s4);
			ang_s5  <= ang_s4;
			side_s5 <= side_s4;
		end
	end

	// final offset, clip and angle rounding
	res_t ra, rb, rc;
	logic sat;

	always_comb begin
		logic signed [RW:0] sx, sy, sz;
		ang_t               t1, t2;
		t1 = side_s5.axy + ang_t'(1 << 15);
		t2 = ang_s5 + ang_t'(1 << 15);
		sx = (RW+1)'(rx_s5) + (RW+1)'(off_x_q);
		sy = (RW+1)'(ry_s5) + (RW+1)'(off_y_q);
		sz = (RW+1)'(side_s5.zv) + (RW+1)'(off_z_q);
		sat = 1'b0;
		if (side_s5.op == OP_CART2SPH) begin
			if (rx_s5 > comp_t'(16777215)) begin
				ra  = res_t'(16777215);
				sat = 1'b1;
			end else if (rx_s5 < comp_t'(-16777216)) begin
				ra  = res_t'(-16777216);
				sat = 1'b1;
			end else begin
				ra = rx_s5[OW-1:0];
			end
			rb = side_s5.ab_zero  ? '0 : res_t'($signed(t1[AW-1:16]));
			rc = side_s5.rho_zero ? '0 : res_t'($signed(t2[AW-1:16]));
		end else begin
			ra = res_t'(sx);
			rb = res_t'(sy);
			rc = res_t'(sz);
			if (sx > 8388607) begin
				ra = res_t'(8388607);  sat = 1'b1;
			end else if (sx < -8388608) begin
				ra = res_t'(-8388608); sat = 1'b1;
			end
			if (sy > 8388607) begin
				rb = res_t'(8388607);  sat = 1'b1;
			end else if (sy < -8388608) begin
				rb = res_t'(-8388608); sat = 1'b1;
			end
			if (sz > 8388607) begin
				rc = res_t'(8388607);  sat = 1'b1;
			end else if (sz < -8388608) begin
				rc = res_t'(-8388608); sat = 1'b1;
			end
		end
	end

	logic out_valid_q;
	res_t oa_q, ob_q, oc_q;
	logic sat_q;
	op_t  op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oa_q  <= ra;
			ob_q  <= rb;
			oc_q  <= rc;
			sat_q <= sat;
			op_q  <= side_s5.op;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, oc_q, ob_q, oa_q};
	assign m_axis_tuser  = sat_q;

`ifndef SYNTHESIS
	a_radius_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && op_q == OP_CART2SPH |-> !oa_q[OW-1])
		else $error("negative radius");

	a_cart_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && op_q == OP_SPH2CART |->
		oa_q[OW-1] == oa_q[OW-2] && ob_q[OW-1] == ob_q[OW-2] && oc_q[OW-1] == oc_q[OW-2])
		else $error("cartesian result outside clip range");
`endif

endmodule

// ===== src/sph_cordic.sv =====
// One pipelined CORDIC pass, one micro-rotation per register stage.
// Depends on sph_pkg; vectoring for op 0, rotation for op 1.
module sph_cordic (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  sph_pkg::cvec_t in_vec,
	input  sph_pkg::side_t in_side,
	output logic           out_valid,
	output sph_pkg::cvec_t out_vec,
	output sph_pkg::side_t out_side
);
	import sph_pkg::*;

	logic  valid_s [CORDIC_STEPS+1];
	cvec_t vec_s   [CORDIC_STEPS+1];
	side_t side_s  [CORDIC_STEPS+1];

	assign valid_s[0] = in_valid;
	assign vec_s[0]   = in_vec;
	assign side_s[0]  = in_side;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
		vec_t  dx;
		vec_t  dy;
		logic  up;
		cvec_t nxt;

		always_comb begin
			dx = $signed(vec_s[i].y) >>> i;
			dy = $signed(vec_s[i].x) >>> i;
			up = (side_s[i].op == OP_CART2SPH) ? ~vec_s[i].y[VW-1] : vec_s[i].a[AW-1];
			nxt.x = up ? vec_s[i].x + dx : vec_s[i].x - dx;
			nxt.y = up ? vec_s[i].y - dy : vec_s[i].y + dy;
			nxt.a = up ? vec_s[i].a + ATAN_TAB[i] : vec_s[i].a - ATAN_TAB[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[i+1]  <= nxt;
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = valid_s[CORDIC_STEPS];
	assign out_vec   = vec_s[CORDIC_STEPS];
	assign out_side  = side_s[CORDIC_STEPS];

endmodule

// ===== tb/spherical_coordinate_convert_test.sv =====
// Self-checking testbench for spherical_coordinate_convert: streams points both ways,
// checks every result against a bit-true CORDIC predictor and sweeps the centre offsets.
// Depends on sph_pkg and the block's RTL.
`timescale 1ns / 100ps

module spherical_coordinate_convert_test;
	import sph_pkg::*;

	localparam int STEPS = CORDIC_STEPS;
	localparam longint HALF = 64'sd2147483648;
	localparam longint QUARTER = 64'sd1073741824;
	localparam longint GAIN_INV = 64'sh26DD3B6A;
	localparam longint ATAN [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	typedef struct packed {
		logic [24:0] ra;
		logic [24:0] rb;
		logic [24:0] rc;
		logic        sat;
	} point_res_t;

	typedef struct packed {
		op_t         op;
		logic [23:0] a;
		logic [23:0] b;
		logic [23:0] c;
		logic        known;
		point_res_t  res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;  // in_a, in_b, in_c
	logic        s_axis_tuser;  // op
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;  // out_a, out_b, out_c, zero pad
	logic        m_axis_tuser;  // saturated
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	longint     off_x, off_y, off_z;
	point_res_t pending_points [$];
	stim_row_t  directed [$];
	int         err_count = 0;
	bit         quiet = 0;
	bit         hold_go = 0;

	spherical_coordinate_convert dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic longint rnd_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint remove_gain(longint v);
		return rnd_shift(rnd_shift(v, 8) * GAIN_INV, 30);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi, inout bit sat);
		if (v < lo) begin
			sat = 1;
			return lo;
		end
		if (v > hi) begin
			sat = 1;
			return hi;
		end
		return v;
	endfunction

	task automatic vectoring(input longint xi, yi, output longint mag, ang);
		longint x, y, a, dx, dy;
		x = xi;
		y = yi;
		a = 0;
		if (x < 0) begin
			a = (y >= 0) ? HALF : -HALF;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; a += ATAN[i];
			end else begin
				x -= dx; y += dy; a -= ATAN[i];
			end
		end
		mag = x;
		ang = a;
	endtask

	task automatic rotate(input longint xi, yi, ai, output longint ox, oy);
		longint x, y, a, dx, dy;
		x = xi;
		y = yi;
		a = ai;
		if (a > QUARTER) begin
			a -= HALF; x = -x; y = -y;
		end else if (a < -QUARTER) begin
			a += HALF; x = -x; y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (a >= 0) begin
				x -= dx; y += dy; a -= ATAN[i];
			end else begin
				x += dx; y -= dy; a += ATAN[i];
			end
		end
		ox = x;
		oy = y;
	endtask

	task automatic convert_point(input op_t op, input logic [23:0] ia, ib, ic,
			output point_res_t r);
		longint a, b, c, mxy, axy, rho, mr, ar, ra, rb, rc, phi, th, zc, sc, zv, xc, yc;
		bit sat;
		a = longint'($signed(ia));
		b = longint'($signed(ib));
		c = longint'($signed(ic));
		sat = 0;
		if (op == OP_CART2SPH) begin
			vectoring(a * 256, b * 256, mxy, axy);
			rho = remove_gain(mxy);
			vectoring(c * 256, rho * 256, mr, ar);
			ra = clamp(remove_gain(mr), -16777216, 16777215, sat);
			rb = (a == 0 && b == 0) ? 0 : rnd_shift(axy, 16);
			rc = (rho == 0 && c == 0) ? 0 : rnd_shift(ar, 16);
		end else begin
			phi = longint'($signed(ib[15:0])) * 65536;
			th = longint'($signed(ic[15:0])) * 65536;
			rotate(a * 256, 0, th, zc, sc);
			zv = remove_gain(zc);
			rho = remove_gain(sc);
			rotate(rho * 256, 0, phi, xc, yc);
			ra = clamp(remove_gain(xc) + off_x, -8388608, 8388607, sat);
			rb = clamp(remove_gain(yc) + off_y, -8388608, 8388607, sat);
			rc = clamp(zv + off_z, -8388608, 8388607, sat);
		end
		r.ra = ra[24:0];
		r.rb = rb[24:0];
		r.rc = rc[24:0];
		r.sat = sat;
	endtask

	task automatic report(input string what, input logic [24:0] got, want);
		err_count++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	task automatic send_point(input op_t op, input logic [23:0] a, b, c, input bit known,
			input point_res_t res);
		point_res_t want;
		bit ok;
		if (!quiet && $urandom_range(3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(14, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {c, b, a};
		s_axis_tuser <= op;
		do begin
			@(negedge clk);
			ok = s_axis_tready;
			@(posedge clk);
		end while (!ok);
		convert_point(op, a, b, c, want);
		if (known && want != res)
			$display("table row disagrees with prediction for %h %h %h", a, b, c);
		pending_points.push_back(known ? res : want);
	endtask

	task automatic write_offset(input reg_t idx, input logic [23:0] val);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		case (idx)
			REG_OFFSET_X: off_x = longint'($signed(val));
			REG_OFFSET_Y: off_y = longint'($signed(val));
			default: off_z = longint'($signed(val));
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_coord;
		case ($urandom_range(3))
			0: return 24'($signed($urandom_range(4096)) - 2048);
			1: return 24'($urandom_range(24'h7FFFFF));
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic random_points(input int n);
		op_t op;
		logic [23:0] a;
		for (int i = 0; i < n; i++) begin
			op = op_t'($urandom_range(1));
			a = rand_coord();
			if (op == OP_SPH2CART && $urandom_range(7) != 0) a[23] = 1'b0;
			send_point(op, a, 24'($urandom), 24'($urandom), 0, '0);
		end
	endtask

	always @(negedge clk) begin
		point_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_points.size() == 0) begin
				err_count++;
				$display("unexpected result at %0t", $realtime);
			end else begin
				want = pending_points.pop_front();
				if (m_axis_tdata[24:0] !== want.ra) report("out_a", m_axis_tdata[24:0], want.ra);
				if (m_axis_tdata[49:25] !== want.rb) report("out_b", m_axis_tdata[49:25], want.rb);
				if (m_axis_tdata[74:50] !== want.rc) report("out_c", m_axis_tdata[74:50], want.rc);
				if (m_axis_tuser !== want.sat) report("saturated", 25'(m_axis_tuser), 25'(want.sat));
			end
		end
	end

	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_go) begin
				hold_go = 0;
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (!quiet && $urandom_range(3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(14, 1)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(20, 1)) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_OFFSET_X;
		cfg_data <= '0;
		off_x = 0;
		off_y = 0;
		off_z = 0;

		directed.push_back('{OP_CART2SPH, 24'h0, 24'h0, 24'h0, 1'b1, '0});
		directed.push_back('{OP_SPH2CART, 24'h0, 24'h001234, 24'h004000, 1'b1, '0});
		directed.push_back('{OP_SPH2CART, 24'h0, 24'hFFFFFF, 24'h800000, 1'b1, '0});
		directed.push_back('{OP_CART2SPH, 24'h0, 24'h0, 24'h7FFFFF, 1'b0, '0});
		directed.push_back('{OP_CART2SPH, 24'h0, 24'h0, 24'h800000, 1'b0, '0});
		directed.push_back('{OP_CART2SPH, 24'h7FFFFF, 24'h0, 24'h0, 1'b0, '0});
		directed.push_back('{OP_CART2SPH, 24'h800000, 24'h0, 24'h0, 1'b0, '0});
		directed.push_back('{OP_CART2SPH, 24'h800000, 24'hFFFFFF, 24'h0, 1'b0, '0});
		directed.push_back('{OP_CART2SPH, 24'h0, 24'h800000, 24'h000001, 1'b0, '0});
		directed.push_back('{OP_CART2SPH, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, '0});
		directed.push_back('{OP_CART2SPH, 24'h800000, 24'h800000, 24'h800000, 1'b0, '0});
		directed.push_back('{OP_CART2SPH, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0, '0});
		directed.push_back('{OP_SPH2CART, 24'h7FFFFF, 24'h0, 24'h4000, 1'b0, '0});
		directed.push_back('{OP_SPH2CART, 24'h7FFFFF, 24'h0, 24'h8000, 1'b0, '0});
		directed.push_back('{OP_SPH2CART, 24'h7FFFFF, 24'h8000, 24'h4000, 1'b0, '0});
		directed.push_back('{OP_SPH2CART, 24'h7FFFFF, 24'hFF7FFF, 24'hFFC000, 1'b0, '0});
		directed.push_back('{OP_SPH2CART, 24'h010000, 24'h7F2000, 24'h002000, 1'b0, '0});
		directed.push_back('{OP_SPH2CART, 24'h800000, 24'h1000, 24'h3000, 1'b0, '0});
		directed.push_back('{OP_SPH2CART, 24'hFF0000, 24'hC000, 24'h7FFF, 1'b0, '0});
		directed.push_back('{OP_SPH2CART, 24'h400000, 24'h4001, 24'h0001, 1'b0, '0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_point(directed[i].op, directed[i].a, directed[i].b, directed[i].c,
				directed[i].known, directed[i].res);
		drain();

		write_offset(REG_OFFSET_X, 24'h7FFFFF);
		write_offset(REG_OFFSET_Y, 24'h7FFFFF);
		write_offset(REG_OFFSET_Z, 24'h7FFFFF);
		hold_go = 1;
		random_points(180);
		drain();

		write_offset(REG_OFFSET_X, 24'h800000);
		write_offset(REG_OFFSET_Y, 24'h800000);
		write_offset(REG_OFFSET_Z, 24'h800000);
		random_points(180);
		drain();

		write_offset(REG_OFFSET_X, 24'($urandom));
		write_offset(REG_OFFSET_Y, 24'($urandom));
		write_offset(REG_OFFSET_Z, 24'($urandom));
		random_points(180);
		drain();

		write_offset(REG_OFFSET_X, 24'($signed($urandom_range(131072)) - 65536));
		write_offset(REG_OFFSET_Y, 24'h0);
		write_offset(REG_OFFSET_Z, 24'($signed($urandom_range(131072)) - 65536));
		random_points(180);
		drain();

		write_offset(REG_OFFSET_X, 24'h0);
		write_offset(REG_OFFSET_Z, 24'h0);
		quiet = 1;
		random_points(180);
		drain();

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
